// ----- rtl/deq_pkg.sv -----
// types, constants and field conversions for the double-ended queue
// shared by deq_cell and double_ended_queue; no dependencies
`default_nettype none

package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int WORD_W     = 32;
  localparam int FCNT_W     = 5;

  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_IN,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    logic               is_empty;
  } out_word_t;

  function automatic logic [DATA_WIDTH-1:0] field_to_data(logic [WORD_W-1:0] f);
    logic [DATA_WIDTH+WORD_W-1:0] ext;
    ext = {{DATA_WIDTH{f[WORD_W-1]}}, f};
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] data_to_field(logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+WORD_W-1:0] ext;
    ext = {{WORD_W{1'b0}}, d};
    return ext[WORD_W-1:0];
  endfunction

  function automatic logic [FCNT_W-1:0] cnt_to_field(logic [CNT_W-1:0] c);
    logic [CNT_W+FCNT_W-1:0] ext;
    ext = {{FCNT_W{1'b0}}, c};
    return ext[FCNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/deq_cell.sv -----
// one storage cell of the queue row: holds a word, loads the new word
// or a neighbor's word as selected; depends on deq_pkg
`default_nettype none

module deq_cell (
  input  logic                            clk,
  input  deq_pkg::cell_sel_t              sel,
  input  logic [deq_pkg::DATA_WIDTH-1:0]  in_val,
  input  logic [deq_pkg::DATA_WIDTH-1:0]  left_val,
  input  logic [deq_pkg::DATA_WIDTH-1:0]  right_val,
  output logic [deq_pkg::DATA_WIDTH-1:0]  word_q
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    case (sel)
      SEL_HOLD:  word_nxt = word_r;
      SEL_IN:    word_nxt = in_val;
      SEL_LEFT:  word_nxt = left_val;
      SEL_RIGHT: word_nxt = right_val;
      default:   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// top level of the double-ended queue: count register, cell row control, result view
// depends on deq_pkg and deq_cell
// result: the result word is on out_word in the cycle after start is taken
// throughput: one word per cycle, busy stays low; cell row and count update together
// reset: synchronous, clears the count and the result strobe; cell contents are kept
`default_nettype none

module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_word_t  in_word,
  output logic               out_valid,
  output deq_pkg::out_word_t out_word
);
  import deq_pkg::*;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  valid_r;
  status_t               status_r;
  status_t               status_nxt;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] back_data;
  cell_sel_t             sel [DEPTH];
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign push_data = field_to_data(in_word.push_value);

  always_comb begin
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SEL_HOLD;
    end
    if (accept) begin
      case (in_word.kind)
        KIND_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            for (int i = 0; i < DEPTH; i++) begin
              if (CNT_W'(i) == count_r) sel[i] = SEL_IN;
            end
          end
        end
        KIND_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            for (int i = 0; i < DEPTH; i++) begin
              sel[i] = (i == 0) ? SEL_IN : SEL_LEFT;
            end
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            for (int i = 0; i < DEPTH; i++) begin
              sel[i] = SEL_RIGHT;
            end
          end
        end
        default: status_nxt = ST_DONE;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic [DATA_WIDTH-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = push_data;
    end else begin : g_mid
      assign left_val = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_q[g];
    end else begin : g_inner
      assign right_val = cell_q[g+1];
    end
    deq_cell u_cell (
      .clk       (clk),
      .sel       (sel[g]),
      .in_val    (push_data),
      .left_val  (left_val),
      .right_val (right_val),
      .word_q    (cell_q[g])
    );
  end

  // back word sits in the cell just below the count
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == count_r) back_data = back_data | cell_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid            = valid_r;
  assign out_word.status      = status_r;
  assign out_word.front_value = empty ? data_to_field('1) : data_to_field(cell_q[0]);
  assign out_word.back_value  = empty ? data_to_field('1) : data_to_field(back_data);
  assign out_word.entry_count = cnt_to_field(count_r);
  assign out_word.is_empty    = empty;

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !full && (in_word.kind == KIND_PUSH_BACK || in_word.kind == KIND_PUSH_FRONT)
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted push did not grow the count");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && empty && (in_word.kind == KIND_POP_BACK || in_word.kind == KIND_POP_FRONT)
    |=> out_word.status == ST_EMPTY && count_r == '0)
    else $error("pop on empty queue not refused");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_FULL |-> count_r == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("accepted word gave no result");

endmodule

`default_nettype wire
